### rtl/bdcg_pkg.sv
// Shared types, constants and register map of the battery duty cycle governor.
package bdcg_pkg;

  localparam int unsigned PeriodW    = 32;
  localparam int unsigned CfgPeriodW = 24;
  localparam int unsigned CfgMvW     = 15;
  localparam int unsigned VoltW      = 16;
  localparam int unsigned UnitsW     = 8;
  localparam int unsigned OpW        = 2;
  localparam int unsigned AccW       = 48;
  localparam int unsigned CntW       = 5;
  localparam int unsigned FixedW     = 21;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned ApbDataW   = 32;

  // Request codes
  localparam logic [OpW-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OpW-1:0] OP_HIB_ON  = 2'd1;
  localparam logic [OpW-1:0] OP_HIB_OFF = 2'd2;
  localparam logic [OpW-1:0] OP_FIXED   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [RegIdxW-1:0] REG_MIN_PERIOD = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_PERIOD = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LOW_MV     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_HIGH_MV    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SHUTDOWN   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_RESTART    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SLEEP_STEP = 3'd6;

  localparam logic [CfgPeriodW-1:0] RST_MIN_PERIOD = 24'd120000;
  localparam logic [CfgPeriodW-1:0] RST_MAX_PERIOD = 24'd1200000;
  localparam logic [CfgMvW-1:0]     RST_LOW_MV     = 15'd3000;
  localparam logic [CfgMvW-1:0]     RST_HIGH_MV    = 15'd4100;
  localparam logic [CfgMvW-1:0]     RST_SHUTDOWN   = 15'd0;
  localparam logic [CfgMvW-1:0]     RST_RESTART    = 15'd0;
  localparam logic [CfgPeriodW-1:0] RST_SLEEP_STEP = 24'd120000;
  localparam logic [PeriodW-1:0]    RST_PERIOD     = 32'd120000;

  // One fixed-delay unit is 5 s
  localparam logic [FixedW-1:0] MS_PER_UNIT = FixedW'(1000 * 5);

  typedef struct packed {
    logic [CfgPeriodW-1:0] min_period_ms;
    logic [CfgPeriodW-1:0] max_period_ms;
    logic [CfgMvW-1:0]     low_voltage_mv;
    logic [CfgMvW-1:0]     high_voltage_mv;
    logic [CfgMvW-1:0]     shutdown_mv;
    logic [CfgMvW-1:0]     restart_mv;
    logic [CfgPeriodW-1:0] sleep_step_ms;
  } cfg_t;

  typedef struct packed {
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
    logic            sub;
  } add_req_t;

endpackage

### rtl/battery_duty_cycle_governor_top.sv
// Top level of the battery duty cycle governor: request decode, sequencer and output register.
// Each request yields one result (period, hibernation flag, variable-mode flag). Commands, fixed
// delays and samples that do not interpolate go straight to the done state. A sample that
// interpolates runs 24 restoring divide steps for the slope, 16 shift-add multiply steps, then
// sign, offset and clamp steps; the divide, multiply, sign and offset steps share one 48-bit
// adder. A sample with equal low and high voltages skips the divide, multiply and sign steps.
// The input side is ready only while the sequencer is idle; a finished result sits in an output
// register, so the next request can be taken while the result waits for the consumer.
module battery_duty_cycle_governor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] op, [17:2] voltage_mv, [25:18] delay_units, [31:26] zero
  input  logic [bdcg_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] period_ms, [32] hibernating, [33] variable_mode, [39:34] zero
  output logic [bdcg_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdcg_pkg::AddrW-1:0]     paddr,
  input  logic [bdcg_pkg::ApbDataW-1:0]  pwdata,
  output logic [bdcg_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import bdcg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_NEG    = 3'd3;
  localparam logic [2:0] ST_ADDMAX = 3'd4;
  localparam logic [2:0] ST_CLAMP  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  cfg_t cfg;

  bdcg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  add_req_t        add_req;
  logic [AccW-1:0] add_sum;

  bdcg_addsub u_addsub (
    .req_i (add_req),
    .sum_o (add_sum)
  );

  logic [OpW-1:0]    in_op;
  logic [VoltW-1:0]  in_volt;
  logic [UnitsW-1:0] in_units;

  assign in_op    = s_axis_tdata[OpW-1:0];
  assign in_volt  = s_axis_tdata[OpW+VoltW-1:OpW];
  assign in_units = s_axis_tdata[OpW+VoltW+UnitsW-1:OpW+VoltW];

  logic [2:0]            state_q, state_d;
  logic                  hib_q, hib_d;
  logic                  follow_q, follow_d;
  logic [VoltW-1:0]      prev_q, prev_d;
  logic [PeriodW-1:0]    period_q, period_d;
  logic [CfgPeriodW-1:0] dq_q, dq_d;
  logic [CfgMvW-1:0]     rem_q, rem_d;
  logic [CfgMvW-1:0]     dvs_q, dvs_d;
  logic [VoltW-1:0]      mlt_q, mlt_d;
  logic [AccW-1:0]       mcand_q, mcand_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  m_valid_q, m_valid_d;
  logic [OutDataW-1:0]   m_data_q, m_data_d;

  // Request decode
  logic                  hib_n, follow_n, interp;
  logic [VoltW-1:0]      prev_n;
  logic [PeriodW-1:0]    per_n;
  logic [PeriodW:0]      sat_sum;
  logic [FixedW-1:0]     fixed_ms;

  // Interpolation setup
  logic                  dt_neg, dv_neg, vl_neg, dv_zero;
  logic [CfgPeriodW-1:0] dt_abs;
  logic [CfgMvW-1:0]     dv_abs;
  logic [VoltW-1:0]      vl_abs, low_ext;

  logic                  in_acc, out_free, qbit;
  logic [VoltW-1:0]      div_shift;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign sat_sum  = {1'b0, period_q} + (PeriodW+1)'(cfg.sleep_step_ms);
  assign fixed_ms = FixedW'(in_units) * MS_PER_UNIT;

  assign low_ext = VoltW'(cfg.low_voltage_mv);
  assign dt_neg  = cfg.max_period_ms > cfg.min_period_ms;
  assign dt_abs  = dt_neg ? cfg.max_period_ms - cfg.min_period_ms
                          : cfg.min_period_ms - cfg.max_period_ms;
  assign dv_neg  = cfg.low_voltage_mv > cfg.high_voltage_mv;
  assign dv_zero = cfg.low_voltage_mv == cfg.high_voltage_mv;
  assign dv_abs  = dv_neg ? cfg.low_voltage_mv - cfg.high_voltage_mv
                          : cfg.high_voltage_mv - cfg.low_voltage_mv;
  assign vl_neg  = low_ext > in_volt;
  assign vl_abs  = vl_neg ? low_ext - in_volt : in_volt - low_ext;

  always_comb begin
    hib_n    = hib_q;
    follow_n = follow_q;
    prev_n   = prev_q;
    per_n    = period_q;
    interp   = 1'b0;
    case (in_op)
      OP_SAMPLE: begin
        if (!hib_n && in_volt <= VoltW'(cfg.shutdown_mv)) begin
          hib_n    = 1'b1;
          follow_n = 1'b0;
          per_n    = PeriodW'(cfg.sleep_step_ms);
          prev_n   = in_volt;
        end
        if (hib_n && in_volt >= VoltW'(cfg.restart_mv)) begin
          hib_n    = 1'b0;
          follow_n = 1'b1;
          per_n    = PeriodW'(cfg.min_period_ms);
        end
        if (hib_n) begin
          // a fresh entry already set prev to this sample, so neither rule fires then
          if (in_volt < prev_n) begin
            per_n = sat_sum[PeriodW] ? '1 : sat_sum[PeriodW-1:0];
          end else if (in_volt > prev_n) begin
            per_n = PeriodW'(cfg.sleep_step_ms);
          end
          prev_n = in_volt;
        end else if (follow_n) begin
          interp = 1'b1;
        end
      end
      OP_HIB_ON: begin
        if (!hib_q) begin
          hib_n    = 1'b1;
          follow_n = 1'b0;
          per_n    = PeriodW'(cfg.sleep_step_ms);
        end
      end
      OP_HIB_OFF: begin
        if (hib_q) begin
          hib_n    = 1'b0;
          follow_n = 1'b1;
          per_n    = PeriodW'(cfg.min_period_ms);
        end
      end
      OP_FIXED: begin
        if (in_units != '0) begin
          follow_n = 1'b0;
          per_n    = PeriodW'(fixed_ms);
        end
      end
      default: ;
    endcase
  end

  assign div_shift = {rem_q, dq_q[CfgPeriodW-1]};
  assign qbit      = !add_sum[AccW-1];

  always_comb begin
    state_d   = state_q;
    hib_d     = hib_q;
    follow_d  = follow_q;
    prev_d    = prev_q;
    period_d  = period_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    mlt_d     = mlt_q;
    mcand_d   = mcand_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    add_req   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hib_d    = hib_n;
          follow_d = follow_n;
          prev_d   = prev_n;
          if (interp) begin
            dq_d  = dt_abs;
            rem_d = '0;
            dvs_d = dv_abs;
            mlt_d = vl_abs;
            neg_d = dt_neg ^ dv_neg ^ vl_neg;
            cnt_d = CntW'(CfgPeriodW - 1);
            acc_d = '0;
            // equal low and high voltages: product taken as zero, go straight to the offset
            state_d = dv_zero ? ST_ADDMAX : ST_DIV;
          end else begin
            period_d = per_n;
            state_d  = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        add_req.a   = AccW'(div_shift);
        add_req.b   = AccW'(dvs_q);
        add_req.sub = 1'b1;
        rem_d = qbit ? add_sum[CfgMvW-1:0] : div_shift[CfgMvW-1:0];
        dq_d  = {dq_q[CfgPeriodW-2:0], qbit};
        if (cnt_q == '0) begin
          mcand_d = AccW'({dq_q[CfgPeriodW-2:0], qbit});
          acc_d   = '0;
          cnt_d   = CntW'(VoltW - 1);
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MUL: begin
        add_req.a   = acc_q;
        add_req.b   = mcand_q;
        add_req.sub = 1'b0;
        if (mlt_q[0]) begin
          acc_d = add_sum;
        end
        mlt_d   = mlt_q >> 1;
        mcand_d = mcand_q << 1;
        if (cnt_q == '0) begin
          state_d = ST_NEG;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_NEG: begin
        add_req.a   = '0;
        add_req.b   = acc_q;
        add_req.sub = 1'b1;
        if (neg_q) begin
          acc_d = add_sum;
        end
        state_d = ST_ADDMAX;
      end
      ST_ADDMAX: begin
        add_req.a   = acc_q;
        add_req.b   = AccW'(cfg.max_period_ms);
        add_req.sub = 1'b0;
        acc_d       = add_sum;
        state_d     = ST_CLAMP;
      end
      ST_CLAMP: begin
        // minimum is checked first; when the two cross, values below it take the minimum, all others the maximum
        if ($signed(acc_q) < $signed(AccW'(cfg.min_period_ms))) begin
          period_d = PeriodW'(cfg.min_period_ms);
        end else if ($signed(acc_q) > $signed(AccW'(cfg.max_period_ms))) begin
          period_d = PeriodW'(cfg.max_period_ms);
        end else begin
          period_d = PeriodW'(acc_q[CfgPeriodW-1:0]);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = OutDataW'({follow_q, hib_q, period_q});
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hib_q     <= 1'b0;
      follow_q  <= 1'b1;
      prev_q    <= '0;
      period_q  <= RST_PERIOD;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      hib_q     <= hib_d;
      follow_q  <= follow_d;
      prev_q    <= prev_d;
      period_q  <= period_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    mlt_q    <= mlt_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    m_data_q <= m_data_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after taking a request");

  a_hib_not_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hib_q |-> !follow_q)
    else $error("hibernation and variable mode active together");

  a_clamp_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLAMP |=> period_q[PeriodW-1:CfgPeriodW] == '0)
    else $error("interpolated period exceeds configured range width");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> m_valid_q && state_q == ST_IDLE)
    else $error("finished result not loaded into output register");

endmodule

### rtl/bdcg_addsub.sv
// Shared wide adder/subtractor used by the divide, multiply, sign and offset steps of the sequencer.
module bdcg_addsub (
  input  bdcg_pkg::add_req_t          req_i,
  output logic [bdcg_pkg::AccW-1:0]   sum_o
);
  import bdcg_pkg::*;

  logic [AccW-1:0] b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = req_i.a + b_op + AccW'(req_i.sub);

endmodule

### rtl/bdcg_cfg.sv
// APB register file holding the governor configuration.
module bdcg_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdcg_pkg::AddrW-1:0]    paddr,
  input  logic [bdcg_pkg::ApbDataW-1:0] pwdata,
  output logic [bdcg_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output bdcg_pkg::cfg_t                cfg_o
);
  import bdcg_pkg::*;

  cfg_t               cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period_ms   <= RST_MIN_PERIOD;
      cfg_q.max_period_ms   <= RST_MAX_PERIOD;
      cfg_q.low_voltage_mv  <= RST_LOW_MV;
      cfg_q.high_voltage_mv <= RST_HIGH_MV;
      cfg_q.shutdown_mv     <= RST_SHUTDOWN;
      cfg_q.restart_mv      <= RST_RESTART;
      cfg_q.sleep_step_ms   <= RST_SLEEP_STEP;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_PERIOD: cfg_q.min_period_ms   <= pwdata[CfgPeriodW-1:0];
        REG_MAX_PERIOD: cfg_q.max_period_ms   <= pwdata[CfgPeriodW-1:0];
        REG_LOW_MV:     cfg_q.low_voltage_mv  <= pwdata[CfgMvW-1:0];
        REG_HIGH_MV:    cfg_q.high_voltage_mv <= pwdata[CfgMvW-1:0];
        REG_SHUTDOWN:   cfg_q.shutdown_mv     <= pwdata[CfgMvW-1:0];
        REG_RESTART:    cfg_q.restart_mv      <= pwdata[CfgMvW-1:0];
        REG_SLEEP_STEP: cfg_q.sleep_step_ms   <= pwdata[CfgPeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_PERIOD: prdata = ApbDataW'(cfg_q.min_period_ms);
      REG_MAX_PERIOD: prdata = ApbDataW'(cfg_q.max_period_ms);
      REG_LOW_MV:     prdata = ApbDataW'(cfg_q.low_voltage_mv);
      REG_HIGH_MV:    prdata = ApbDataW'(cfg_q.high_voltage_mv);
      REG_SHUTDOWN:   prdata = ApbDataW'(cfg_q.shutdown_mv);
      REG_RESTART:    prdata = ApbDataW'(cfg_q.restart_mv);
      REG_SLEEP_STEP: prdata = ApbDataW'(cfg_q.sleep_step_ms);
      default:        prdata = '0;
    endcase
  end

endmodule
